// ----- hdl/fpr_pkg.sv -----
// Shared types and constants for the FIFO page replacement block.
// No dependencies; imported by every module of the block.
package fpr_pkg;

  localparam int ADDR_W    = 32;
  localparam int PB_W      = 17;
  localparam int FIU_W     = 5;
  localparam int SLOT_W    = 4;
  localparam int CFG_IDX_W = 8;
  localparam int REM_W     = PB_W + 1;
  localparam int DIV_STEPS = ADDR_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = CFG_IDX_W'(1);

  localparam logic [PB_W-1:0]   PAGE_BYTES_RST    = PB_W'(4096);
  localparam logic [FIU_W-1:0]  FRAMES_IN_USE_RST = FIU_W'(16);
  localparam logic [ADDR_W-1:0] FAULT_MAX         = '1;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quot;
  } div_res_t;

endpackage

// ----- hdl/fpr_div.sv -----
// Serial restoring divider: one quotient bit per cycle.
// Depends on fpr_pkg.
module fpr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fpr_pkg::ADDR_W-1:0] dividend,
  input  logic [fpr_pkg::PB_W-1:0]  divisor,
  output fpr_pkg::div_res_t         res
);
  import fpr_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   cnt_r;
  logic [REM_W-1:0]    rem_r;
  logic [ADDR_W-1:0]   quo_r;
  logic [PB_W-1:0]     dvs_r;
  logic [REM_W-1:0]    shifted;
  logic                ge;
  logic [REM_W-1:0]    rem_nxt;

  always_comb begin
    shifted = {rem_r[REM_W-2:0], quo_r[ADDR_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? (shifted - {1'b0, dvs_r}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= (divisor == '0) ? PB_W'(1) : divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[ADDR_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = quo_r;

endmodule

// ----- hdl/fpr_frame_mem.sv -----
// Frame page store: one write port, one read port, registered read data.
// Depends on fpr_pkg.
module fpr_frame_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [IDX_W-1:0]           waddr,
  input  logic [fpr_pkg::ADDR_W-1:0] wdata,
  input  logic                       re,
  input  logic [IDX_W-1:0]           raddr,
  output logic [fpr_pkg::ADDR_W-1:0] rdata
);
  import fpr_pkg::*;

  logic [ADDR_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_q[raddr];
    end
  end

endmodule

// ----- hdl/fifo_page_replacement_top.sv -----
// FIFO page replacement top level: config registers, control sequencer, valid bits.
// Depends on fpr_pkg, fpr_div and fpr_frame_mem.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | start / busy         | in_address
//  out     | out_valid (1 cycle)  | out_page_number, out_fault, out_frame_slot,
//          |                      | out_fault_total
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// A request runs the serial divider, then scans the frame store one entry per cycle over
// the n active frames; a miss scans all of them, an early hit ends the scan sooner.
// busy drops in the cycle the result strobes, so the next request can start then.
// Synchronous active-low reset clears all frames to invalid; no clearing pass is needed.
// The receiver cannot stall; cfg_ready is always high.
module fifo_page_replacement_top #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fpr_pkg::ADDR_W-1:0]    in_address,
  output logic                          out_valid,
  output logic [fpr_pkg::ADDR_W-1:0]    out_page_number,
  output logic                          out_fault,
  output logic [fpr_pkg::SLOT_W-1:0]    out_frame_slot,
  output logic [fpr_pkg::ADDR_W-1:0]    out_fault_total,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpr_pkg::PB_W-1:0]      cfg_wdata
);
  import fpr_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SCAN} state_t;

  state_t              state_r;
  logic [PB_W-1:0]     page_bytes_r;
  logic [FIU_W-1:0]    frames_in_use_r;
  logic [MAX_FRAMES-1:0] valid_r;
  logic [IDX_W-1:0]    fill_ptr_r;
  logic [ADDR_W-1:0]   fault_cnt_r;
  logic [ADDR_W-1:0]   page_r;
  logic [CNT_W-1:0]    n_r;
  logic [CNT_W-1:0]    issue_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                cmp_vld_r;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_page_r;
  logic                out_fault_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [ADDR_W-1:0]   out_total_r;

  div_res_t            div_res;
  logic                div_start;
  logic [ADDR_W-1:0]   rd_data;
  logic [CNT_W-1:0]    n_act;
  logic                hit_now;
  logic                miss_now;
  logic                re;
  logic [IDX_W-1:0]    slot_fill;
  logic [CNT_W-1:0]    slot_inc;
  logic [IDX_W-1:0]    fill_nxt;
  logic [ADDR_W-1:0]   fault_nxt;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign div_start = start && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bytes_r    <= PAGE_BYTES_RST;
      frames_in_use_r <= FRAMES_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAGE_BYTES:    page_bytes_r    <= cfg_wdata;
        CFG_FRAMES_IN_USE: frames_in_use_r <= cfg_wdata[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  fpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_address),
    .divisor  (page_bytes_r),
    .res      (div_res)
  );

  fpr_frame_mem #(
    .DEPTH (MAX_FRAMES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (miss_now),
    .waddr (slot_fill),
    .wdata (page_r),
    .re    (re),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    if (frames_in_use_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(frames_in_use_r) > 32'(MAX_FRAMES)) begin
      n_act = CNT_W'(MAX_FRAMES);
    end else begin
      n_act = CNT_W'(frames_in_use_r);
    end
    hit_now   = (state_r == S_SCAN) && cmp_vld_r && valid_r[cmp_idx_r] && (rd_data == page_r);
    re        = (state_r == S_SCAN) && !hit_now && (issue_r < n_r);
    miss_now  = (state_r == S_SCAN) && !hit_now && !cmp_vld_r && (issue_r >= n_r);
    slot_fill = (CNT_W'(fill_ptr_r) < n_r) ? fill_ptr_r : '0;
    slot_inc  = CNT_W'(slot_fill) + CNT_W'(1);
    fill_nxt  = (slot_inc >= n_r) ? '0 : slot_inc[IDX_W-1:0];
    fault_nxt = (fault_cnt_r == FAULT_MAX) ? fault_cnt_r : fault_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      fill_ptr_r  <= '0;
      fault_cnt_r <= '0;
      cmp_vld_r   <= 1'b0;
      issue_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            page_r    <= div_res.quot;
            n_r       <= n_act;
            issue_r   <= '0;
            cmp_vld_r <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld_r <= re;
          cmp_idx_r <= issue_r[IDX_W-1:0];
          if (re) begin
            issue_r <= issue_r + 1'b1;
          end
          if (hit_now) begin
            out_valid_r <= 1'b1;
            out_page_r  <= page_r;
            out_fault_r <= 1'b0;
            out_slot_r  <= SLOT_W'(cmp_idx_r);
            out_total_r <= fault_cnt_r;
            state_r     <= S_IDLE;
          end else if (miss_now) begin
            valid_r[slot_fill] <= 1'b1;
            fill_ptr_r  <= fill_nxt;
            fault_cnt_r <= fault_nxt;
            out_valid_r <= 1'b1;
            out_page_r  <= page_r;
            out_fault_r <= 1'b1;
            out_slot_r  <= SLOT_W'(slot_fill);
            out_total_r <= fault_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_page_number = out_page_r;
  assign out_fault       = out_fault_r;
  assign out_frame_slot  = out_slot_r;
  assign out_fault_total = out_total_r;

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_fault_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault) |-> (out_fault_total != '0))
    else $error("fault reported with zero fault count");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_ptr_r) < 32'(MAX_FRAMES))
    else $error("fill pointer out of range");
`endif

endmodule
